/* sv/rrts_pkg.sv */
`default_nettype none
package rrts_pkg;
    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_BLOCK   = 3'd2,
        REQ_UNBLOCK = 3'd3,
        REQ_REMOVE  = 3'd4
    } t_req;

    localparam logic [2:0] RSN_WAIT      = 3'd0;
    localparam logic [2:0] RSN_WAITCHILD = 3'd1;
    localparam logic [2:0] RSN_READ      = 3'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_RD,
        S_INS_SCAN,
        S_UB_RD,
        S_UB_EVAL,
        S_UB_SHIFT_RD,
        S_UB_SHIFT_WR,
        S_RM_RD,
        S_RM_EVAL,
        S_RM_SHIFT_RD,
        S_RM_SHIFT_WR,
        S_OUT_RD,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

/* sv/round_robin_task_scheduler.sv */
// Round-robin task scheduler: slot table, ready ring and blocked list in
// on-chip memories with registered reads. Unblock and remove walk the lists
// entry by entry and, on a hit, compact the list by shifting later entries down.
// One request at a time: the next request is accepted only after the result
// has been taken.
// Reset (synchronous, active low): lists empty, no valid slots, idle task current, idle_pid 0.
`default_nettype none
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_type[2:0], pid[10:3], parent_pid[18:11], tty_id[22:19],
    // reason[25:23], wait_ticks[41:26], zero[47:42]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // next_pid[7:0], ran_idle[8], woken_count[13:9], status_code[15:14]
    output logic [15:0]      m_axis_tdata
);
    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] NMAX = CW'(MAX_TASKS);

    // memories: slot table and the two lists
    logic [15:0]   m_ids    [MAX_TASKS];
    logic [2:0]    m_reason [MAX_TASKS];
    logic [15:0]   m_wait   [MAX_TASKS];
    logic [3:0]    m_tty    [MAX_TASKS];
    logic [SW-1:0] m_ring   [MAX_TASKS];
    logic [SW-1:0] m_blk    [MAX_TASKS];

    t_state r_state, n_state;
    logic [MAX_TASKS-1:0] r_valid, n_valid;
    logic [SW-1:0] r_head, n_head;
    logic [CW-1:0] r_rcnt, n_rcnt, r_bcnt, n_bcnt;
    logic [SW-1:0] r_cur, n_cur;
    logic          r_cur_idle, n_cur_idle, r_cur_blk, n_cur_blk;
    logic [7:0]    r_idle_pid;
    logic [7:0]    r_cur_ppid, n_cur_ppid;   // parent pid of current task
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic          r_phase2, n_phase2;       // remove: blocked list pass
    logic [4:0]    r_woken, n_woken;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_pid, r_ppid;
    logic [3:0]    r_tty;
    logic [2:0]    r_rsn;
    logic [SW-1:0] r_s, n_s;
    logic          r_oval, n_oval;
    logic [15:0]   r_odata, n_odata;

    // read ports
    logic [SW-1:0] ring_ra, blk_ra, slot_ra;
    logic [SW-1:0] r_ring_q, r_blk_q;
    logic [15:0]   r_ids_q, r_wait_q;
    logic [2:0]    r_rsn_q;
    logic [3:0]    r_tty_q;
    // write ports
    logic          ring_we, blk_we, ids_we, rw_we;
    logic [SW-1:0] ring_wa, blk_wa, ids_wa, rw_wa, ring_wd, blk_wd;
    logic [15:0]   ids_wd, wait_wd;
    logic [2:0]    rsn_wd;
    logic [3:0]    tty_wd;
    logic          tty_we;

    always_ff @(posedge i_clk) begin
        r_ring_q <= m_ring[ring_ra];
        r_blk_q  <= m_blk[blk_ra];
        r_ids_q  <= m_ids[slot_ra];
        r_rsn_q  <= m_reason[slot_ra];
        r_wait_q <= m_wait[slot_ra];
        r_tty_q  <= m_tty[slot_ra];
        if (ring_we) begin
            m_ring[ring_wa] <= ring_wd;
        end
        if (blk_we) begin
            m_blk[blk_wa] <= blk_wd;
        end
        if (ids_we) begin
            m_ids[ids_wa] <= ids_wd;
        end
        if (tty_we) begin
            m_tty[ids_wa] <= tty_wd;
        end
        if (rw_we) begin
            m_reason[rw_wa] <= rsn_wd;
            m_wait[rw_wa]   <= wait_wd;
        end
    end

    function automatic logic [SW-1:0] ring_at(input logic [SW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] t;
        begin
            t = {1'b0, CW'(h)} + {1'b0, k};
            if (t >= (CW+1)'(MAX_TASKS)) begin
                t = t - (CW+1)'(MAX_TASKS);
            end
            ring_at = t[SW-1:0];
        end
    endfunction

    logic in_acc;
    assign s_axis_tready = (r_state == S_IDLE) && !r_oval;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    logic [SW-1:0] free_idx;
    logic          free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int k = MAX_TASKS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = SW'(k);
                free_ok  = 1'b1;
            end
        end
    end

    logic wake, stop;
    always_comb begin
        n_state = r_state; n_valid = r_valid; n_head = r_head; n_rcnt = r_rcnt;
        n_bcnt = r_bcnt; n_cur = r_cur; n_cur_idle = r_cur_idle; n_cur_blk = r_cur_blk;
        n_cur_ppid = r_cur_ppid; n_i = r_i; n_j = r_j; n_phase2 = r_phase2;
        n_woken = r_woken; n_status = r_status; n_s = r_s; n_oval = r_oval;
        n_odata = r_odata;
        ring_ra = r_head; blk_ra = '0; slot_ra = r_cur;
        ring_we = 1'b0; blk_we = 1'b0; ids_we = 1'b0; rw_we = 1'b0; tty_we = 1'b0;
        ring_wa = '0; blk_wa = '0; ids_wa = '0; rw_wa = '0; ring_wd = '0; blk_wd = '0;
        ids_wd = '0; wait_wd = '0; rsn_wd = '0; tty_wd = '0;
        wake = 1'b0; stop = 1'b0;
        if (r_oval && m_axis_tready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_woken = '0; n_status = ST_OK; n_i = '0; n_phase2 = 1'b0;
                    case (t_req'(s_axis_tdata[2:0]))
                        REQ_TICK: begin
                            // requeue or park current, then pop
                            if (!r_cur_idle) begin
                                if (r_cur_blk) begin
                                    if (r_bcnt < NMAX) begin
                                        blk_we = 1'b1; blk_wa = r_bcnt[SW-1:0];
                                        blk_wd = r_cur; n_bcnt = r_bcnt + 1'b1;
                                    end
                                end else if (r_rcnt < NMAX) begin
                                    ring_we = 1'b1; ring_wa = ring_at(r_head, r_rcnt);
                                    ring_wd = r_cur; n_rcnt = r_rcnt + 1'b1;
                                end
                            end
                            n_cur_blk = 1'b0;
                            n_state = S_TICK_RD;
                        end
                        REQ_INSERT: n_state = S_INS_SCAN;
                        REQ_BLOCK: begin
                            if (!r_cur_idle) begin
                                rw_we = 1'b1; rw_wa = r_cur;
                                rsn_wd = s_axis_tdata[25:23];
                                wait_wd = s_axis_tdata[41:26];
                                n_cur_blk = 1'b1;
                            end
                            n_state = S_OUT_RD;
                        end
                        REQ_UNBLOCK: n_state = S_UB_RD;
                        REQ_REMOVE: n_state = S_RM_RD;
                        default: n_state = S_OUT_RD;
                    endcase
                end
            end
            S_TICK_RD: begin
                // ring write of the requeue landed last cycle; read head now
                ring_ra = r_head;
                if (r_rcnt == '0) begin
                    n_cur_idle = 1'b1;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_OUT;  // wait for the registered ring read
                    n_phase2 = 1'b1;
                end
            end
            S_INS_SCAN: begin
                if (!free_ok) begin
                    n_status = ST_FULL;
                end else begin
                    n_valid[free_idx] = 1'b1;
                    ids_we = 1'b1; ids_wa = free_idx; ids_wd = {r_pid, r_ppid};
                    tty_we = 1'b1; tty_wd = r_tty;
                    rw_we = 1'b1; rw_wa = free_idx; rsn_wd = '0; wait_wd = '0;
                    if (r_rcnt < NMAX) begin
                        ring_we = 1'b1; ring_wa = ring_at(r_head, r_rcnt);
                        ring_wd = free_idx; n_rcnt = r_rcnt + 1'b1;
                    end
                end
                n_state = S_OUT_RD;
            end
            S_UB_RD: begin
                if (r_i >= r_bcnt) begin
                    n_state = S_OUT_RD;
                end else begin
                    blk_ra = r_i[SW-1:0];
                    n_state = S_UB_EVAL;
                    n_phase2 = 1'b0;
                end
            end
            S_UB_EVAL: begin
                // phase 1: blk read back, issue slot read; phase 2: evaluate
                if (!r_phase2) begin
                    slot_ra = r_blk_q; n_s = r_blk_q; n_phase2 = 1'b1;
                end else begin
                    n_phase2 = 1'b0;
                    if (r_rsn_q == r_rsn) begin
                        if (r_rsn == RSN_WAIT) begin
                            if (r_wait_q == '0) begin
                                wake = 1'b1;
                            end else begin
                                rw_we = 1'b1; rw_wa = r_s; rsn_wd = r_rsn_q;
                                wait_wd = r_wait_q - 16'd1;
                            end
                        end else if (r_rsn == RSN_WAITCHILD) begin
                            wake = !r_cur_idle && (r_cur_ppid == r_ids_q[15:8]);
                        end else if (r_rsn == RSN_READ) begin
                            wake = (r_tty_q == r_tty); stop = wake;
                        end else begin
                            wake = 1'b1;
                        end
                    end
                    if (wake) begin
                        if (r_rcnt < NMAX) begin
                            ring_we = 1'b1; ring_wa = ring_at(r_head, r_rcnt);
                            ring_wd = r_s; n_rcnt = r_rcnt + 1'b1;
                        end
                        if (r_woken != 5'd31) begin
                            n_woken = r_woken + 5'd1;
                        end
                        n_j = r_i;
                        n_status = stop ? ST_NOT_FOUND : ST_OK;  // stop marker
                        n_state = S_UB_SHIFT_RD;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_UB_RD;
                    end
                end
            end
            S_UB_SHIFT_RD, S_RM_SHIFT_RD: begin
                // compact list from index r_j
                if (r_phase2) begin
                    if (r_j + 1'b1 < r_rcnt) begin
                        ring_ra = ring_at(r_head, r_j + 1'b1);
                        n_state = S_RM_SHIFT_WR;
                    end else begin
                        n_rcnt = r_rcnt - 1'b1;
                        n_state = S_OUT_RD;
                    end
                end else if (r_j + 1'b1 < r_bcnt) begin
                    blk_ra = r_j[SW-1:0] + 1'b1;
                    n_state = (r_state == S_UB_SHIFT_RD) ? S_UB_SHIFT_WR : S_RM_SHIFT_WR;
                end else begin
                    n_bcnt = r_bcnt - 1'b1;
                    if (r_state == S_UB_SHIFT_RD && r_status == ST_OK) begin
                        n_state = S_UB_RD;
                    end else begin
                        n_status = ST_OK;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_UB_SHIFT_WR, S_RM_SHIFT_WR: begin
                if (r_phase2) begin
                    ring_we = 1'b1; ring_wa = ring_at(r_head, r_j); ring_wd = r_ring_q;
                end else begin
                    blk_we = 1'b1; blk_wa = r_j[SW-1:0]; blk_wd = r_blk_q;
                end
                n_j = r_j + 1'b1;
                n_state = (r_state == S_UB_SHIFT_WR) ? S_UB_SHIFT_RD : S_RM_SHIFT_RD;
            end
            S_RM_RD: begin
                if (!r_phase2 && r_i >= r_rcnt) begin
                    n_phase2 = 1'b1; n_i = '0;
                end else if (r_phase2 && r_i >= r_bcnt) begin
                    n_status = ST_NOT_FOUND; n_phase2 = 1'b0; n_state = S_OUT_RD;
                end else begin
                    ring_ra = ring_at(r_head, r_i); blk_ra = r_i[SW-1:0];
                    n_j = '0; n_state = S_RM_EVAL;
                end
            end
            S_RM_EVAL: begin
                if (r_j == '0) begin
                    n_s = r_phase2 ? r_blk_q : r_ring_q;
                    slot_ra = n_s; n_j = CW'(1);
                end else if (r_ids_q[15:8] == r_pid) begin
                    n_valid[r_s] = 1'b0;
                    n_j = r_i;
                    // phase2 inverted: ring shift uses phase2=1 in shift states
                    n_phase2 = !r_phase2;
                    n_state = S_RM_SHIFT_RD;
                end else begin
                    n_i = r_i + 1'b1; n_state = S_RM_RD;
                end
            end
            S_OUT_RD: begin
                slot_ra = r_cur;
                n_phase2 = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_phase2) begin
                    // tick pop: ring data valid now
                    n_cur = r_ring_q; n_cur_idle = 1'b0;
                    n_head = (r_head == SW'(MAX_TASKS - 1)) ? '0 : r_head + 1'b1;
                    n_rcnt = r_rcnt - 1'b1;
                    n_state = S_OUT_RD;
                end else begin
                    n_cur_ppid = r_ids_q[7:0];
                    n_odata = {r_status, r_woken, r_cur_idle,
                               r_cur_idle ? r_idle_pid : r_ids_q[15:8]};
                    n_oval = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_head <= '0; r_rcnt <= '0; r_bcnt <= '0;
            r_cur <= '0; r_cur_idle <= 1'b1; r_cur_blk <= 1'b0; r_oval <= 1'b0;
            r_idle_pid <= '0; r_phase2 <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_head <= n_head; r_rcnt <= n_rcnt;
            r_bcnt <= n_bcnt; r_cur <= n_cur; r_cur_idle <= n_cur_idle;
            r_cur_blk <= n_cur_blk; r_oval <= n_oval; r_phase2 <= n_phase2;
            if (i_cfg_we) begin
                r_idle_pid <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_ppid <= n_cur_ppid; r_i <= n_i; r_j <= n_j; r_woken <= n_woken;
        r_status <= n_status; r_s <= n_s; r_odata <= n_odata;
        if (in_acc) begin
            r_pid <= s_axis_tdata[10:3];
            r_ppid <= s_axis_tdata[18:11]; r_tty <= s_axis_tdata[22:19];
            r_rsn <= s_axis_tdata[25:23];
        end
    end

    // a woken entry sits in the ring before the blocked list shrinks, so the
    // two counts are bounded separately
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rcnt <= NMAX) && (r_bcnt <= NMAX)) else $error("list overflow");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && !m_axis_tready) |=> (r_oval && $stable(r_odata)))
        else $error("output lost");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("accept while busy");
endmodule
`default_nettype wire
